// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;
	localparam int EXT_W   = 17;	// holds any page sum for the largest map
	localparam int BYTE_W  = 8;

	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

	// Result of running the free-page counter across one map byte.
	typedef struct packed {
		logic             hit;		// run reached the requested length
		logic [2:0]       hit_bit;	// page offset in the byte where it did
		logic [CNT_W-1:0] run;		// free run length carried to the next byte
	} scan_res_t;

endpackage

// ===== src/bitmap_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a used-page bitmap held in a byte memory.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; the map memory moves one byte per cycle.
// Allocate: scans bytes up to the hit, then marks the bytes in the run;
//   a failed allocate scans the whole map.
// Free: marks the bytes touched (about count/8); clear: sweeps the whole map.
// Reset: control clears at once, then a clearing pass over all MAP_BYTES
//   bytes zeroes the map; in_stall stays high until it is done.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAP_BYTES = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [IDX_W-1:0]  page_index,
	input  logic [CNT_W-1:0]  count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              success,
	output logic [IDX_W-1:0]  start_page
);

	// Byte address and page index widths follow the map size.
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int PW = AW + 3;
	localparam logic [AW-1:0]    LAST_ADDR  = AW'(MAP_BYTES - 1);
	localparam logic [EXT_W-1:0] PAGE_TOTAL = EXT_W'(MAP_BYTES * 8);

	// Sequencer states.
	localparam logic [2:0] ST_CLR  = 3'd0;	// sweep zeros through the map
	localparam logic [2:0] ST_IDLE = 3'd1;	// wait for an item
	localparam logic [2:0] ST_SCAN = 3'd2;	// search for the first fitting run
	localparam logic [2:0] ST_MARK = 3'd3;	// set or clear a page range
	localparam logic [2:0] ST_RESP = 3'd4;	// hand the result to the output

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_addr_q;		// clearing pass position
	logic              clr_reply_q;		// clear came from an item, not reset
	logic [AW-1:0]     byte_q;			// byte whose read data is arriving
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  run_q;
	logic [PW-1:0]     lo_q;
	logic [PW-1:0]     hi_q;
	logic              set_q;			// mark range used (alloc) or free
	logic              res_ok_q;
	logic [IDX_W-1:0]  res_start_q;
	logic              out_valid_q;
	logic              success_q;
	logic [IDX_W-1:0]  start_page_q;

	logic              accept;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic [BYTE_W-1:0] range_mask;
	logic [EXT_W-1:0]  free_end;
	logic              free_ok;
	logic [EXT_W-1:0]  free_hi;
	logic [PW-1:0]     hit_page;
	logic [EXT_W-1:0]  alloc_lo;
	logic              out_free;
	scan_res_t         scan;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign start_page = start_page_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Free range check: one past the last page must not pass the map end.
	assign free_end = EXT_W'(page_index) + EXT_W'(count);
	assign free_ok  = (free_end <= PAGE_TOTAL);
	assign free_hi  = free_end - EXT_W'(1);

	// Run start from the page where the run completed.
	assign hit_page = {byte_q, scan.hit_bit};
	assign alloc_lo = EXT_W'(hit_page) + EXT_W'(1) - EXT_W'(cnt_q);

	bpa_map_ram #(
		.DEPTH (MAP_BYTES),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bpa_byte_scan u_scan (
		.map_byte (rd_data),
		.run_in   (run_q),
		.cnt      (cnt_q),
		.res      (scan)
	);

	// Pages of the current byte that fall inside [lo, hi]; MSB is lowest page.
	always_comb begin
		logic [PW-1:0] pg;
		pg = '0;
		for (int j = 0; j < 8; j++) begin
			pg = {byte_q, 3'(j)};
			range_mask[7-j] = (pg >= lo_q) && (pg <= hi_q);
		end
	end

	// Memory port control. Reads stream one byte ahead; the write in MARK
	// always targets the byte before the one being read, so no hazard arises.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FN_ALLOC && count != '0) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end else if (accept && func == FN_FREE && count != '0 && free_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(page_index >> 3);
				end
			end
			ST_SCAN: begin
				if (scan.hit) begin
					rd_en   = 1'b1;
					rd_addr = alloc_lo[PW-1:3];
				end else if (byte_q != LAST_ADDR) begin
					rd_en   = 1'b1;
					rd_addr = byte_q + AW'(1);
				end
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = byte_q;
				wr_data = set_q ? (rd_data | range_mask) : (rd_data & ~range_mask);
				if (byte_q != hi_q[PW-1:3]) begin
					rd_en   = 1'b1;
					rd_addr = byte_q + AW'(1);
				end
			end
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the output item once taken, unless RESP reloads it below.
			if (out_valid_q && !out_stall && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_addr_q == LAST_ADDR) begin
						clr_addr_q <= '0;
						if (clr_reply_q) begin
							res_ok_q    <= 1'b1;
							res_start_q <= '0;
							state_q     <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						// Only a zero-length free succeeds without touching the map here.
						res_ok_q    <= (func == FN_FREE) && (count == '0);
						res_start_q <= '0;
						cnt_q       <= count;
						run_q       <= '0;
						case (func)
							FN_ALLOC: begin
								if (count != '0) begin
									byte_q  <= '0;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_RESP;
								end
							end
							FN_FREE: begin
								if (count != '0 && free_ok) begin
									lo_q    <= PW'(page_index);
									hi_q    <= free_hi[PW-1:0];
									byte_q  <= AW'(page_index >> 3);
									set_q   <= 1'b0;
									state_q <= ST_MARK;
								end else begin
									state_q <= ST_RESP;
								end
							end
							FN_CLEAR: begin
								clr_addr_q  <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan.hit) begin
						lo_q        <= alloc_lo[PW-1:0];
						hi_q        <= hit_page;
						byte_q      <= alloc_lo[PW-1:3];
						set_q       <= 1'b1;
						res_start_q <= alloc_lo[IDX_W-1:0];
						state_q     <= ST_MARK;
					end else if (byte_q == LAST_ADDR) begin
						state_q <= ST_RESP;
					end else begin
						run_q  <= scan.run;
						byte_q <= byte_q + AW'(1);
					end
				end
				ST_MARK: begin
					if (byte_q == hi_q[PW-1:3]) begin
						res_ok_q <= 1'b1;
						state_q  <= ST_RESP;
					end else begin
						byte_q <= byte_q + AW'(1);
					end
				end
				ST_RESP: begin
					// Hold until the output register is free.
					if (out_free) begin
						out_valid_q  <= 1'b1;
						success_q    <= res_ok_q;
						start_page_q <= res_start_q;
						clr_reply_q  <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_map_ram
// Byte-wide map memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_map_ram
	import bpa_pkg::*;
#(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/bpa_byte_scan.sv =====
// ----------------------------------------------------------------------------
// bpa_byte_scan
// Extend the free run across the eight pages of one map byte, lowest page
// (MSB) first, and flag the page where the run reaches the wanted length.
// ----------------------------------------------------------------------------
module bpa_byte_scan
	import bpa_pkg::*;
(
	input  logic [BYTE_W-1:0] map_byte,
	input  logic [CNT_W-1:0]  run_in,
	input  logic [CNT_W-1:0]  cnt,
	output scan_res_t         res
);

	always_comb begin
		logic [CNT_W-1:0] run;
		logic             hit;
		logic [2:0]       hit_bit;
		run     = run_in;
		hit     = 1'b0;
		hit_bit = 3'd0;
		for (int j = 0; j < 8; j++) begin
			if (!hit) begin
				if (map_byte[7-j]) begin
					run = '0;
				end else begin
					run = run + CNT_W'(1);
				end
				if (run == cnt) begin
					hit     = 1'b1;
					hit_bit = 3'(j);
				end
			end
		end
		res.hit     = hit;
		res.hit_bit = hit_bit;
		res.run     = run;
	end

endmodule
